@@ sv/dosq_pkg.sv @@
// dosq_pkg: shared types and codes for the dual order service queue
// no dependencies; used by the top unit and by dosq_pick
package dosq_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int PRIORITY_BITS_DEF = 20;

    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 20;
    localparam int STATUS_W = 2;
    localparam int TICKET_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OLDEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICKET_W-1:0] ticket;
    } rsp_t;

    typedef struct packed {
        logic             clear;
        logic             eval;
        logic [CMD_W-1:0] cmd;
    } pick_ctl_t;

endpackage

@@ sv/dual_order_service_queue_unit.sv @@
// dual_order_service_queue_unit: slot table with serve-oldest and serve-best
// every command scans all CAPACITY slots through one compare unit:
// the result beat is registered after the scan, and a new command is taken only once the last one is done
// after reset a clearing pass over all CAPACITY slots holds busy high
// each result beat shows for one cycle on rsp_valid; the receiver cannot stall
// depends on dosq_pkg, dosq_mem and dosq_pick
module dual_order_service_queue_unit #(
    parameter int CAPACITY      = dosq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = dosq_pkg::PRIORITY_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dosq_pkg::req_t req,
    output dosq_pkg::rsp_t rsp,
    output logic           rsp_valid
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TW     = dosq_pkg::TICKET_W;
    localparam int WORD_W = 1 + TW + PRIORITY_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [dosq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [PRIORITY_BITS-1:0]      prio_reg, prio_next;
    logic [TW-1:0]                 next_arrival_reg, next_arrival_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;
    dosq_pkg::rsp_t                rsp_reg, rsp_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic [PRIORITY_BITS-1:0]      prio_in;
    logic                          we, re;
    logic [IDX_W-1:0]              waddr, raddr;
    logic [WORD_W-1:0]             wdata, rdata;
    dosq_pkg::pick_ctl_t           pick_ctl;
    logic                          found;
    logic [IDX_W-1:0]              best_idx;
    logic [TW-1:0]                 best_arrival;
    logic [PRIORITY_BITS-1:0]      best_prio;

    generate
        if (PRIORITY_BITS <= dosq_pkg::PRIO_W)
        begin : g_prio_cut
            assign prio_in = req.priority_req[PRIORITY_BITS-1:0];
        end
        else
        begin : g_prio_ext
            assign prio_in = {{(PRIORITY_BITS - dosq_pkg::PRIO_W){1'b0}}, req.priority_req};
        end
    endgenerate

    dosq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    dosq_pick #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pick_ctl),
        .cand_valid   (rdata[WORD_W-1]),
        .cand_arrival (rdata[WORD_W-2:PRIORITY_BITS]),
        .cand_prio    (rdata[PRIORITY_BITS-1:0]),
        .cand_idx     (rd_idx_reg),
        .found        (found),
        .best_idx     (best_idx),
        .best_arrival (best_arrival),
        .best_prio    (best_prio)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cmd_next          = cmd_reg;
        prio_next         = prio_reg;
        next_arrival_next = next_arrival_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = 1'b0;
        we                = 1'b0;
        waddr             = cnt_reg[IDX_W-1:0];
        wdata             = '0;
        re                = 1'b0;
        raddr             = cnt_reg[IDX_W-1:0];
        pick_ctl.clear    = 1'b0;
        pick_ctl.eval     = 1'b0;
        pick_ctl.cmd      = cmd_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == CNT_W'(CAPACITY - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = req.cmd;
                    prio_next      = prio_in;
                    cnt_next       = '0;
                    pick_ctl.clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pick_ctl.eval = rd_vld_reg;
                if (cnt_reg < CNT_W'(CAPACITY))
                begin
                    re       = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_vld_reg && (rd_idx_reg == IDX_W'(CAPACITY - 1)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                rsp_valid_next = 1'b1;
                waddr          = best_idx;
                rsp_next.ticket = '0;
                if (cmd_reg == dosq_pkg::CMD_INSERT)
                begin
                    if (!found || (next_arrival_reg == {TW{1'b1}}))
                    begin
                        rsp_next.status = dosq_pkg::ST_FULL;
                    end
                    else
                    begin
                        we                = 1'b1;
                        wdata             = {1'b1, next_arrival_reg, prio_reg};
                        next_arrival_next = next_arrival_reg + 1'b1;
                        rsp_next.status   = dosq_pkg::ST_INSERTED;
                        rsp_next.ticket   = next_arrival_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!found)
                    begin
                        rsp_next.status = dosq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        we              = 1'b1;
                        wdata           = {1'b0, best_arrival, best_prio};
                        rsp_next.status = dosq_pkg::ST_SERVED;
                        rsp_next.ticket = best_arrival + 1'b1;
                    end
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_vld_next = re;
        rd_idx_next = raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cnt_reg          <= '0;
            next_arrival_reg <= '0;
            rd_vld_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            next_arrival_reg <= next_arrival_next;
            rd_vld_reg       <= rd_vld_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        prio_reg   <= prio_next;
        rd_idx_reg <= rd_idx_next;
        rsp_reg    <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ sv/dosq_mem.sv @@
// dosq_mem: slot table storage, one write port and one registered read port
// depends on nothing
module dosq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 53
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dosq_pick.sv @@
// dosq_pick: shared compare unit that keeps the running choice during a scan
// depends on dosq_pkg
module dosq_pick #(
    parameter int CAPACITY      = dosq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = dosq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dosq_pkg::pick_ctl_t           ctl,
    input  logic                          cand_valid,
    input  logic [dosq_pkg::TICKET_W-1:0] cand_arrival,
    input  logic [PRIORITY_BITS-1:0]      cand_prio,
    input  logic [$clog2(CAPACITY)-1:0]   cand_idx,
    output logic                          found,
    output logic [$clog2(CAPACITY)-1:0]   best_idx,
    output logic [dosq_pkg::TICKET_W-1:0] best_arrival,
    output logic [PRIORITY_BITS-1:0]      best_prio
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                          found_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [dosq_pkg::TICKET_W-1:0] arrival_reg;
    logic [PRIORITY_BITS-1:0]      prio_reg;
    logic                          take;

    always_comb
    begin
        priority if (ctl.cmd == dosq_pkg::CMD_INSERT)
        begin
            take = !cand_valid && !found_reg;
        end
        else if (ctl.cmd[1])
        begin
            take = cand_valid && (!found_reg || (cand_prio > prio_reg) ||
                   ((cand_prio == prio_reg) && (cand_arrival < arrival_reg)));
        end
        else
        begin
            take = cand_valid && (!found_reg || (cand_arrival < arrival_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.eval && take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.eval && take)
        begin
            idx_reg     <= cand_idx;
            arrival_reg <= cand_arrival;
            prio_reg    <= cand_prio;
        end
    end

    assign found        = found_reg;
    assign best_idx     = idx_reg;
    assign best_arrival = arrival_reg;
    assign best_prio    = prio_reg;

endmodule

@@ test/dual_order_service_queue_unit_tb.sv @@
// testbench for dual_order_service_queue_unit: directed and random insert and serve beats,
// checked against a slot-table predictor held in a small scoreboard class
// depends on dosq_pkg and the dual_order_service_queue_unit rtl
module dual_order_service_queue_unit_tb;

    localparam int SLOTS        = dosq_pkg::CAPACITY_DEF;
    localparam int CMD_W        = dosq_pkg::CMD_W;
    localparam int PRIO_W       = dosq_pkg::PRIO_W;
    localparam int TICKET_W     = dosq_pkg::TICKET_W;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
    localparam logic [TICKET_W-1:0] TICKET_LAST = 32'hFFFF_FFFF;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 50;

    class service_scoreboard;
        bit                  slot_used [SLOTS];
        logic [TICKET_W-1:0] slot_ticket [SLOTS];
        logic [PRIO_W-1:0]   slot_prio [SLOTS];
        logic [TICKET_W-1:0] next_ticket = '0;
        dosq_pkg::rsp_t      pending [$];
        int                  errors = 0;

        function dosq_pkg::rsp_t predict_response(dosq_pkg::req_t r);
            dosq_pkg::rsp_t res;
            int             found;
            bit             best;
            found      = -1;
            res.ticket = '0;
            if (r.cmd == dosq_pkg::CMD_INSERT)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_used[i] && found < 0)
                        found = i;
                end
                if (found < 0 || next_ticket == TICKET_LAST)
                    res.status = dosq_pkg::ST_FULL;
                else
                begin
                    slot_used[found]   = 1'b1;
                    slot_ticket[found] = next_ticket;
                    slot_prio[found]   = r.priority_req;
                    next_ticket        = next_ticket + 1;
                    res.ticket         = next_ticket;
                    res.status         = dosq_pkg::ST_INSERTED;
                end
            end
            else
            begin
                // high bit of the command selects the priority order
                best = r.cmd[1];
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (found < 0)
                            found = i;
                        else if (best)
                        begin
                            if (slot_prio[i] > slot_prio[found] ||
                                (slot_prio[i] == slot_prio[found] &&
                                 slot_ticket[i] < slot_ticket[found]))
                                found = i;
                        end
                        else if (slot_ticket[i] < slot_ticket[found])
                            found = i;
                    end
                end
                if (found < 0)
                    res.status = dosq_pkg::ST_EMPTY;
                else
                begin
                    slot_used[found] = 1'b0;
                    res.ticket       = slot_ticket[found] + 1;
                    res.status       = dosq_pkg::ST_SERVED;
                end
            end
            return res;
        endfunction

        function void note_request(dosq_pkg::req_t r);
            pending = {pending, predict_response(r)};
        endfunction

        function void check_response(dosq_pkg::rsp_t got);
            dosq_pkg::rsp_t exp_rsp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat, got status %0d ticket %0d",
                         $time, got.status, got.ticket);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (got.status !== exp_rsp.status)
            begin
                $display("%0t: status expected %0d, got %0d",
                         $time, exp_rsp.status, got.status);
                errors++;
            end
            if (got.ticket !== exp_rsp.ticket)
            begin
                $display("%0t: ticket expected %0d, got %0d",
                         $time, exp_rsp.ticket, got.ticket);
                errors++;
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    dosq_pkg::req_t req = '0;
    logic           busy;
    dosq_pkg::rsp_t rsp;
    logic           rsp_valid;

    service_scoreboard sb = new;

    dual_order_service_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1)
            sb.check_response(rsp);
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [PRIO_W-1:0] prio);
        dosq_pkg::req_t r;
        r.cmd          = cmd;
        r.priority_req = prio;
        req   <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    task automatic pause_requests();
        start <= 1'b0;
        // sometimes let the block go idle first so the gap lands after the scan
        if ($urandom_range(0, 1) == 1)
        begin
            do
                @(posedge clk);
            while (busy !== 1'b0);
        end
        repeat ($urandom_range(1, 3)) @(posedge clk);
    endtask

    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [PRIO_W-1:0] prio;
        int                ins_weight;
        int                pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // serves on an empty table, then extremes, ties and every command
        send_request(dosq_pkg::CMD_OLDEST, 20'h00000);
        send_request(dosq_pkg::CMD_BEST,   20'hFFFFF);
        send_request(CMD_UNDEF,            20'h12345);
        send_request(dosq_pkg::CMD_INSERT, 20'h00000);
        send_request(dosq_pkg::CMD_INSERT, 20'hFFFFF);
        send_request(dosq_pkg::CMD_INSERT, 20'hFFFFF);
        send_request(dosq_pkg::CMD_INSERT, 20'h00000);
        pause_requests();
        send_request(dosq_pkg::CMD_INSERT, 20'hAAAAA);
        send_request(dosq_pkg::CMD_INSERT, 20'h55555);
        send_request(dosq_pkg::CMD_BEST,   20'h00000);
        send_request(CMD_UNDEF,            20'h00000);
        send_request(dosq_pkg::CMD_OLDEST, 20'hFFFFF);
        send_request(dosq_pkg::CMD_BEST,   20'h00000);
        send_request(dosq_pkg::CMD_INSERT, 20'h00001);
        send_request(dosq_pkg::CMD_INSERT, 20'h80000);
        send_request(dosq_pkg::CMD_OLDEST, 20'h00000);
        send_request(dosq_pkg::CMD_BEST,   20'h00000);
        send_request(dosq_pkg::CMD_BEST,   20'h00000);
        send_request(dosq_pkg::CMD_OLDEST, 20'h00000);
        send_request(dosq_pkg::CMD_BEST,   20'h00000);
        send_request(dosq_pkg::CMD_INSERT, 20'h00007);

        // phases alternate between filling past capacity and draining past empty
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i / 80)
                0:       ins_weight = 95;
                1:       ins_weight = 40;
                2:       ins_weight = 15;
                3:       ins_weight = 90;
                default: ins_weight = 30;
            endcase
            if ($urandom_range(1, 100) <= ins_weight)
                cmd = dosq_pkg::CMD_INSERT;
            else
            begin
                pick = $urandom_range(1, 100);
                if (pick <= 45)
                    cmd = dosq_pkg::CMD_OLDEST;
                else if (pick <= 90)
                    cmd = dosq_pkg::CMD_BEST;
                else
                    cmd = CMD_UNDEF;
            end
            pick = $urandom_range(1, 10);
            if (pick <= 5)
                prio = 20'($urandom_range(0, 3));
            else if (pick == 6)
                prio = ($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'h00000;
            else
                prio = 20'($urandom());
            send_request(cmd, prio);
            if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                pause_requests();
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ dual_order_service_queue_unit.f @@
sv/dosq_pkg.sv
sv/dosq_mem.sv
sv/dosq_pick.sv
sv/dual_order_service_queue_unit.sv
test/dual_order_service_queue_unit_tb.sv
